FILE: sv/krq_pkg.sv
// ----------------------------------------------------------------------------
// krq_pkg: shared types and constants of the key repeat event queue
// Holds the request codes, the word structs of both channels, the register
// indexes and the control structs between the top level and the ring.
// ----------------------------------------------------------------------------
package krq_pkg;

  // Request codes carried in req_type; codes 6 and 7 act as a status query
  typedef enum logic [2:0] {
    REQ_PRESS     = 3'd0,
    REQ_RELEASE   = 3'd1,
    REQ_TICK      = 3'd2,
    REQ_READ_KEY  = 3'd3,
    REQ_READ_SCAN = 3'd4,
    REQ_STATUS    = 3'd5
  } req_t;

  // Configuration register indexes
  localparam logic CFG_REPEAT_DELAY  = 1'b0;
  localparam logic CFG_REPEAT_PERIOD = 1'b1;

  localparam logic [15:0] REPEAT_DELAY_RST  = 16'd800;
  localparam logic [15:0] REPEAT_PERIOD_RST = 16'd50;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] key_code;
    logic [7:0] oem_code;
    logic [7:0] modifier_bits;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       key_available;
    logic       scan_available;
    logic [7:0] held_scan;
    logic [7:0] held_modifiers;
    logic       key_held;
  } out_word_t;

  // Commands into the ring, at most one of them per cycle
  typedef struct packed {
    logic enq;
    logic deq;
    logic flush;
  } ring_cmd_t;

  // Ring status, all from registers
  typedef struct packed {
    logic empty;
    logic key_nz;
    logic scan_nz;
  } ring_stat_t;

endpackage

FILE: sv/krq_ring.sv
// ----------------------------------------------------------------------------
// krq_ring: key and scan code rings with shared pointers
// Two synchronous memories written at the slot after the write pointer and
// read at the slot after the read pointer, read data registered.
// ----------------------------------------------------------------------------
module krq_ring #(
  parameter int RING_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  krq_pkg::ring_cmd_t     cmd,
  input  logic [7:0]             enq_key,
  input  logic [7:0]             enq_scan,
  output krq_pkg::ring_stat_t    stat,
  output logic [7:0]             rd_key,
  output logic [7:0]             rd_scan
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  logic [7:0]       key_mem  [RING_DEPTH];
  logic [7:0]       scan_mem [RING_DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic             key_nz_r;
  logic             scan_nz_r;
  logic [7:0]       rd_key_r;
  logic [7:0]       rd_scan_r;
  logic [PTR_W-1:0] wr_slot;
  logic [PTR_W-1:0] rd_slot;
  logic             full;
  logic             empty;
  logic             do_enq;
  logic             do_deq;

  assign wr_slot = ptr_inc(wptr_r);
  assign rd_slot = ptr_inc(rptr_r);
  assign full    = (wr_slot == rptr_r);
  assign empty   = (wptr_r == rptr_r);
  assign do_enq  = cmd.enq && !full;
  assign do_deq  = cmd.deq && !empty;

  // Memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (do_enq) begin
      key_mem[wr_slot]  <= enq_key;
      scan_mem[wr_slot] <= enq_scan;
    end
    if (do_deq) begin
      rd_key_r  <= key_mem[rd_slot];
      rd_scan_r <= scan_mem[rd_slot];
    end
  end

  // Pointers and the zero flags of the newest entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r    <= '0;
      rptr_r    <= '0;
      key_nz_r  <= 1'b0;
      scan_nz_r <= 1'b0;
    end else if (cmd.flush) begin
      wptr_r    <= '0;
      rptr_r    <= '0;
      key_nz_r  <= 1'b0;
      scan_nz_r <= 1'b0;
    end else begin
      if (do_enq) begin
        wptr_r    <= wr_slot;
        key_nz_r  <= (enq_key != 8'd0);
        scan_nz_r <= (enq_scan != 8'd0);
      end
      if (do_deq) begin
        rptr_r <= rd_slot;
      end
    end
  end

  assign stat.empty   = empty;
  assign stat.key_nz  = key_nz_r;
  assign stat.scan_nz = scan_nz_r;
  assign rd_key       = rd_key_r;
  assign rd_scan      = rd_scan_r;

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (wptr_r == rptr_r))
    else $error("ring not empty after flush");

  a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq && full && !cmd.flush |=> $stable(wptr_r))
    else $error("write pointer moved on a full ring");

  a_empty_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq && empty && !cmd.flush |=> $stable(rptr_r))
    else $error("read pointer moved on an empty ring");

endmodule

FILE: sv/key_repeat_event_queue_top.sv
// ----------------------------------------------------------------------------
// key_repeat_event_queue_top: keyboard event queue with typematic repeat
// Takes press, release, tick, read and status requests, keeps the held key
// and its repeat timers, and queues key and scan codes in a ring memory.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+--------------------------
//  in_      | input     | in_valid / in_ready     | in_data  (in_word_t)
//  out_     | output    | out_valid / out_ready   | out_data (out_word_t)
//  cfg_     | input     | cfg_we, no wait         | cfg_idx, cfg_wdata
//
//  One word is accepted per cycle while in_ready is high. Its result word is
//  formed in the cycle after acceptance, once the ring memory has returned
//  the read data, and lands in the output register once that is free.
//  Reset (synchronous, rst_n low) empties the ring, clears the held key and
//  the timers, and loads delay 800 ticks and period 50 ticks.
//  A stalled output register holds its word; a second word then waits in the
//  result stage and in_ready drops until the output frees.
//
module key_repeat_event_queue_top #(
  parameter int RING_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  krq_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output krq_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [15:0]         cfg_wdata
);

  // Configuration
  logic [15:0] delay_r;
  logic [15:0] period_r;

  // Held key and timers
  logic        held_flag_r;
  logic        held_flag_nxt;
  logic [7:0]  held_key_r;
  logic [7:0]  held_key_nxt;
  logic [7:0]  held_scan_r;
  logic [7:0]  held_scan_nxt;
  logic [7:0]  held_mod_r;
  logic [7:0]  held_mod_nxt;
  logic [15:0] held_time_r;
  logic [15:0] held_time_nxt;
  logic [15:0] period_cnt_r;
  logic [15:0] period_cnt_nxt;
  logic [15:0] period_cnt_inc;
  logic [15:0] period_eff;

  // Result stage and output register
  logic                 pend_r;
  logic                 pend_scan_r;
  logic                 pend_hit_r;
  logic                 out_valid_r;
  krq_pkg::out_word_t   out_data_r;
  krq_pkg::out_word_t   result;
  logic                 out_free;
  logic                 accept;

  // Ring interface
  krq_pkg::ring_cmd_t   cmd;
  krq_pkg::ring_stat_t  stat;
  logic [7:0]           enq_key;
  logic [7:0]           enq_scan;
  logic [7:0]           rd_key;
  logic [7:0]           rd_scan;
  logic                 is_read;
  logic                 is_scan_read;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !pend_r || out_free;
  assign accept   = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= krq_pkg::REPEAT_DELAY_RST;
      period_r <= krq_pkg::REPEAT_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        krq_pkg::CFG_REPEAT_DELAY:  delay_r  <= cfg_wdata;
        krq_pkg::CFG_REPEAT_PERIOD: period_r <= cfg_wdata;
        default:                    delay_r  <= delay_r;
      endcase
    end
  end

  // A zero period behaves as one: expire on every tick
  assign period_eff     = (period_r == 16'd0) ? 16'd1 : period_r;
  assign period_cnt_inc = period_cnt_r + 16'd1;

  // Decode the request and work out the next held state
  always_comb begin
    held_flag_nxt  = held_flag_r;
    held_key_nxt   = held_key_r;
    held_scan_nxt  = held_scan_r;
    held_mod_nxt   = held_mod_r;
    held_time_nxt  = held_time_r;
    period_cnt_nxt = period_cnt_r;
    enq_key        = held_key_r;
    enq_scan       = held_scan_r;
    cmd            = '0;
    is_read        = 1'b0;
    is_scan_read   = 1'b0;
    unique case (krq_pkg::req_t'(in_data.req_type))
      krq_pkg::REQ_PRESS: begin
        // Latch the new key, restart the held time, queue its codes
        held_flag_nxt = 1'b1;
        held_key_nxt  = in_data.key_code;
        held_scan_nxt = in_data.oem_code;
        held_mod_nxt  = in_data.modifier_bits;
        held_time_nxt = 16'd0;
        enq_key       = in_data.key_code;
        enq_scan      = in_data.oem_code;
        cmd.enq       = 1'b1;
      end
      krq_pkg::REQ_RELEASE: begin
        // Flush only when a key was down
        cmd.flush     = held_flag_r;
        held_flag_nxt = 1'b0;
        held_key_nxt  = 8'd0;
        held_scan_nxt = 8'd0;
        held_mod_nxt  = 8'd0;
      end
      krq_pkg::REQ_TICK: begin
        if (held_time_r != 16'hFFFF) begin
          held_time_nxt = held_time_r + 16'd1;
        end
        if (period_cnt_inc >= period_eff) begin
          // Period expired: repeat the held codes once past the delay
          period_cnt_nxt = 16'd0;
          cmd.enq        = held_flag_r && (held_time_nxt > delay_r);
        end else begin
          period_cnt_nxt = period_cnt_inc;
        end
      end
      krq_pkg::REQ_READ_KEY: begin
        cmd.deq = 1'b1;
        is_read = 1'b1;
      end
      krq_pkg::REQ_READ_SCAN: begin
        cmd.deq      = 1'b1;
        is_read      = 1'b1;
        is_scan_read = 1'b1;
      end
      default: begin
        // Status query and unused codes: no change
        is_read = 1'b0;
      end
    endcase
    if (!accept) begin
      cmd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_flag_r  <= 1'b0;
      held_key_r   <= 8'd0;
      held_scan_r  <= 8'd0;
      held_mod_r   <= 8'd0;
      held_time_r  <= 16'd0;
      period_cnt_r <= 16'd0;
    end else if (accept) begin
      held_flag_r  <= held_flag_nxt;
      held_key_r   <= held_key_nxt;
      held_scan_r  <= held_scan_nxt;
      held_mod_r   <= held_mod_nxt;
      held_time_r  <= held_time_nxt;
      period_cnt_r <= period_cnt_nxt;
    end
  end

  krq_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .enq_key  (enq_key),
    .enq_scan (enq_scan),
    .stat     (stat),
    .rd_key   (rd_key),
    .rd_scan  (rd_scan)
  );

  // Result stage: remember what the accepted word needs from the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (accept) begin
      pend_r <= 1'b1;
    end else if (out_free) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_scan_r <= is_scan_read;
      pend_hit_r  <= is_read && !stat.empty;
    end
  end

  // State registers already hold the state after the pending word
  always_comb begin
    result.read_data      = pend_hit_r ? (pend_scan_r ? rd_scan : rd_key) : 8'd0;
    result.key_available  = !stat.empty && stat.key_nz;
    result.scan_available = !stat.empty && stat.scan_nz;
    result.held_scan      = held_scan_r;
    result.held_modifiers = held_mod_r;
    result.key_held       = held_flag_r;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_pends: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> pend_r)
    else $error("accepted word left no pending result");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while the result stage is blocked");

  a_pend_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !out_valid_r |=> out_valid_r)
    else $error("pending result not loaded into a free output");

endmodule
